### hdl/cdn_pkg.sv
// Shared constants and calendar helper functions for the date normalizer.
// No dependencies; used by calendar_date_normalize_add.
package cdn_pkg;

  localparam int DAY_WIDTH_DEF  = 16;
  localparam int YEAR_WIDTH_DEF = 14;
  localparam int MONTH_WIDTH    = 8;
  localparam int RES_WIDTH      = 9;

  localparam logic [17:0] DAYS_PER_400Y = 18'd146097;
  localparam logic [8:0]  RES_LAST      = 9'd399;
  localparam logic [9:0]  CYCLE_YEARS   = 10'd400;

  localparam logic [3:0] MON_JAN = 4'd1;
  localparam logic [3:0] MON_FEB = 4'd2;
  localparam logic [3:0] MON_APR = 4'd4;
  localparam logic [3:0] MON_JUN = 4'd6;
  localparam logic [3:0] MON_SEP = 4'd9;
  localparam logic [3:0] MON_NOV = 4'd11;
  localparam logic [3:0] MON_DEC = 4'd12;

  // Leap test from the year modulo 400.
  function automatic logic is_leap(input logic [RES_WIDTH-1:0] r);
    logic century;
    century = (r == 9'd100) || (r == 9'd200) || (r == 9'd300);
    return (r[1:0] == 2'b00) && !century;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    if (m == MON_APR || m == MON_JUN || m == MON_SEP || m == MON_NOV) begin
      len = 5'd30;
    end else if (m == MON_FEB) begin
      len = leap ? 5'd29 : 5'd28;
    end else begin
      len = 5'd31;
    end
    return len;
  endfunction

  function automatic logic [8:0] year_len(input logic leap);
    return leap ? 9'd366 : 9'd365;
  endfunction

endpackage

### hdl/calendar_date_normalize_add.sv
// Gregorian date normalizer with optional componentwise add of two dates.
// Depends on cdn_pkg (constants, month and year length functions).
//
// Channel  Ports                               Handshake
// input    in_op, in_day_a .. in_year_b        start & !busy
// result   out_day_out, out_month_out,         out_valid, one-cycle strobe
//          out_year_out, out_year_overflow
//
// One shared subtractor removes a month, a year or a 400-year cycle of days
// per cycle; year mod 400 comes from a reciprocal multiply whose quotient is registered.
// Each date pass: year mod 400 (an add instead on the sum pass), month wrap, month steps,
// 400-year steps, year steps, a second month walk, then finish; op=1 runs passes for a, b
// and their sum. busy is high from accept until the strobe cycle.
// rst_n is synchronous; the receiver cannot stall the result.
module calendar_date_normalize_add #(
  parameter int DAY_WIDTH  = cdn_pkg::DAY_WIDTH_DEF,
  parameter int YEAR_WIDTH = cdn_pkg::YEAR_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_op,
  input  logic [DAY_WIDTH-1:0]               in_day_a,
  input  logic [cdn_pkg::MONTH_WIDTH-1:0]    in_month_a,
  input  logic [YEAR_WIDTH-1:0]              in_year_a,
  input  logic [DAY_WIDTH-1:0]               in_day_b,
  input  logic [cdn_pkg::MONTH_WIDTH-1:0]    in_month_b,
  input  logic [YEAR_WIDTH-1:0]              in_year_b,
  output logic                               out_valid,
  output logic [4:0]                         out_day_out,
  output logic [3:0]                         out_month_out,
  output logic [YEAR_WIDTH-1:0]              out_year_out,
  output logic                               out_year_overflow
);

  localparam int MW = (DAY_WIDTH > YEAR_WIDTH) ? DAY_WIDTH : YEAR_WIDTH;
  localparam int YI = MW + 3;
  localparam int DI = (DAY_WIDTH > 6) ? DAY_WIDTH : 6;
  localparam int DC = (DI > 18) ? DI : 18;
  localparam int MN = cdn_pkg::MONTH_WIDTH;
  localparam int RW = cdn_pkg::RES_WIDTH;

  // floor(y / 400) = floor((y >> 4) / 25), the latter by reciprocal multiply.
  localparam int QW  = YEAR_WIDTH - 4;
  localparam int RCW = QW + 1;
  localparam int RS  = QW + 5;
  localparam longint unsigned DIV25 = 64'(cdn_pkg::CYCLE_YEARS) >> 4;
  localparam logic [RCW-1:0] RECIP = RCW'(((64'd1 << RS) + DIV25 - 64'd1) / DIV25);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_MOD   = 9'b000000010,
    S_MWRAP = 9'b000000100,
    S_WALK1 = 9'b000001000,
    S_CYC   = 9'b000010000,
    S_YRS   = 9'b000100000,
    S_WALK2 = 9'b001000000,
    S_NEXT  = 9'b010000000,
    S_SUM   = 9'b100000000
  } state_t;

  typedef enum logic [2:0] {
    PH_A   = 3'b001,
    PH_B   = 3'b010,
    PH_SUM = 3'b100
  } phase_t;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;

  logic [DI-1:0]  d_r, d_nxt;
  logic [MN-1:0]  m_r, m_nxt;
  logic [YI-1:0]  y_r, y_nxt;
  logic [RW-1:0]  r_r, r_nxt;
  logic           cnt_r, cnt_nxt;
  logic [QW-1:0]  quo_r, quo_nxt;

  logic                  op_r;
  logic [DAY_WIDTH-1:0]  b_day_r;
  logic [MN-1:0]         b_month_r;
  logic [YEAR_WIDTH-1:0] b_year_r;

  logic [4:0]    sa_d_r, sa_d_nxt;
  logic [3:0]    sa_m_r, sa_m_nxt;
  logic [YI-1:0] sa_y_r, sa_y_nxt;
  logic [RW-1:0] sa_r_r, sa_r_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [4:0]            out_day_r, out_day_nxt;
  logic [3:0]            out_month_r, out_month_nxt;
  logic [YEAR_WIDTH-1:0] out_year_r, out_year_nxt;
  logic                  out_ovf_r, out_ovf_nxt;

  logic             accept;
  logic             leap;
  logic [DC-1:0]    sub;
  logic [DC:0]      diff_w;
  logic             gt;
  logic [DI-1:0]    d_sub;
  logic [YI-1:0]    y_inc;
  logic [RW-1:0]    r_inc;
  logic [YEAR_WIDTH-1:0] y_lo;
  logic [QW-1:0]    y_q;
  logic [2*QW:0]    q_prod;
  logic [YEAR_WIDTH-1:0] q400;
  logic [RW-1:0]    r_mod;
  logic [RW:0]      rsum;
  logic [RW-1:0]    r_add;
  logic [YI-1:0]    ymax;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  // Shared subtractor: day count minus the selected length.
  assign leap = cdn_pkg::is_leap(r_r);
  always_comb begin
    if (state_r == S_CYC) begin
      sub = DC'(cdn_pkg::DAYS_PER_400Y);
    end else if (state_r == S_YRS) begin
      sub = DC'(cdn_pkg::year_len(leap));
    end else begin
      sub = DC'(cdn_pkg::month_len(m_r[3:0], leap));
    end
  end
  assign diff_w = {1'b0, DC'(d_r)} - {1'b0, sub};
  assign gt     = !diff_w[DC] && (diff_w[DC-1:0] != '0);
  assign d_sub  = diff_w[DI-1:0];

  assign y_inc = y_r + YI'(1);
  assign r_inc = (r_r == cdn_pkg::RES_LAST) ? '0 : r_r + RW'(1);

  // Year mod 400: the quotient is registered first, then the remainder is taken.
  assign y_lo   = y_r[YEAR_WIDTH-1:0];
  assign y_q    = y_lo[YEAR_WIDTH-1:4];
  assign q_prod = {{RCW{1'b0}}, y_q} * {{QW{1'b0}}, RECIP};
  assign q400   = YEAR_WIDTH'(quo_r) * YEAR_WIDTH'(cdn_pkg::CYCLE_YEARS);
  assign r_mod  = RW'(y_lo - q400);
  assign rsum  = {1'b0, sa_r_r} + {1'b0, r_r};
  assign r_add = (rsum >= cdn_pkg::CYCLE_YEARS) ? RW'(rsum - cdn_pkg::CYCLE_YEARS)
                                                : rsum[RW-1:0];
  assign ymax  = YI'({YEAR_WIDTH{1'b1}});

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    d_nxt         = d_r;
    m_nxt         = m_r;
    y_nxt         = y_r;
    r_nxt         = r_r;
    cnt_nxt       = cnt_r;
    quo_nxt       = quo_r;
    sa_d_nxt      = sa_d_r;
    sa_m_nxt      = sa_m_r;
    sa_y_nxt      = sa_y_r;
    sa_r_nxt      = sa_r_r;
    out_valid_nxt = 1'b0;
    out_day_nxt   = out_day_r;
    out_month_nxt = out_month_r;
    out_year_nxt  = out_year_r;
    out_ovf_nxt   = out_ovf_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          d_nxt     = (in_day_a == '0) ? DI'(1) : DI'(in_day_a);
          m_nxt     = (in_month_a == '0) ? MN'(1) : in_month_a;
          y_nxt     = (in_year_a == '0) ? YI'(1) : YI'(in_year_a);
          r_nxt     = '0;
          cnt_nxt   = 1'b1;
          phase_nxt = PH_A;
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        if (cnt_r) begin
          quo_nxt = QW'(q_prod >> RS);
          cnt_nxt = 1'b0;
        end else begin
          r_nxt     = r_mod;
          state_nxt = S_MWRAP;
        end
      end
      S_MWRAP: begin
        if (m_r > MN'(12)) begin
          m_nxt = m_r - MN'(12);
          y_nxt = y_inc;
          r_nxt = r_inc;
        end else begin
          state_nxt = S_WALK1;
        end
      end
      S_WALK1, S_WALK2: begin
        if (state_r == S_WALK1 && m_r[3:0] == cdn_pkg::MON_JAN) begin
          state_nxt = S_CYC;
        end else if (gt) begin
          d_nxt = d_sub;
          if (m_r[3:0] == cdn_pkg::MON_DEC) begin
            m_nxt = MN'(1);
            y_nxt = y_inc;
            r_nxt = r_inc;
          end else begin
            m_nxt = m_r + MN'(1);
          end
        end else begin
          state_nxt = S_NEXT;
        end
      end
      S_CYC: begin
        if (gt) begin
          d_nxt = d_sub;
          y_nxt = y_r + YI'(cdn_pkg::CYCLE_YEARS);
        end else begin
          state_nxt = S_YRS;
        end
      end
      S_YRS: begin
        if (gt) begin
          d_nxt = d_sub;
          y_nxt = y_inc;
          r_nxt = r_inc;
        end else begin
          state_nxt = S_WALK2;
        end
      end
      S_NEXT: begin
        if (phase_r == PH_A && op_r) begin
          sa_d_nxt  = d_r[4:0];
          sa_m_nxt  = m_r[3:0];
          sa_y_nxt  = y_r;
          sa_r_nxt  = r_r;
          d_nxt     = (b_day_r == '0) ? DI'(1) : DI'(b_day_r);
          m_nxt     = (b_month_r == '0) ? MN'(1) : b_month_r;
          y_nxt     = (b_year_r == '0) ? YI'(1) : YI'(b_year_r);
          r_nxt     = '0;
          cnt_nxt   = 1'b1;
          phase_nxt = PH_B;
          state_nxt = S_MOD;
        end else if (phase_r == PH_B) begin
          phase_nxt = PH_SUM;
          state_nxt = S_SUM;
        end else begin
          out_valid_nxt = 1'b1;
          out_day_nxt   = d_r[4:0];
          out_month_nxt = m_r[3:0];
          out_ovf_nxt   = (y_r > ymax);
          out_year_nxt  = (y_r > ymax) ? {YEAR_WIDTH{1'b1}} : y_r[YEAR_WIDTH-1:0];
          state_nxt     = S_IDLE;
        end
      end
      S_SUM: begin
        d_nxt     = DI'(sa_d_r) + d_r;
        m_nxt     = MN'(sa_m_r) + m_r;
        y_nxt     = sa_y_r + y_r;
        r_nxt     = r_add;
        state_nxt = S_MWRAP;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_A;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_r         <= d_nxt;
    m_r         <= m_nxt;
    y_r         <= y_nxt;
    r_r         <= r_nxt;
    cnt_r       <= cnt_nxt;
    quo_r       <= quo_nxt;
    sa_d_r      <= sa_d_nxt;
    sa_m_r      <= sa_m_nxt;
    sa_y_r      <= sa_y_nxt;
    sa_r_r      <= sa_r_nxt;
    out_day_r   <= out_day_nxt;
    out_month_r <= out_month_nxt;
    out_year_r  <= out_year_nxt;
    out_ovf_r   <= out_ovf_nxt;
    if (accept) begin
      op_r      <= in_op;
      b_day_r   <= in_day_b;
      b_month_r <= in_month_b;
      b_year_r  <= in_year_b;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_day_out       = out_day_r;
  assign out_month_out     = out_month_r;
  assign out_year_out      = out_year_r;
  assign out_year_overflow = out_ovf_r;

endmodule
